FILE: rtl/tkm_pkg.sv
// Shared types and constants for the top-k magnitude pair selector.
package tkm_pkg;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int MAG_W   = 31;
    localparam int FRAC_W  = 17;
    localparam int TOTAL_W = 20;
    localparam int FRAC_BITS = 16;

    localparam int MAX_GENES_DEF = 1024;
    localparam int MAX_KEPT_DEF  = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [FRAC_W-1:0]  FRAC_RESET = 17'd655;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
    localparam logic [MAG_W-1:0]   MAG_MAX    = '1;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last_entry;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        pair_row;
        logic [IDX_W-1:0]        pair_col;
        logic signed [VAL_W-1:0] pair_value;
        logic [MAG_W-1:0]        pair_magnitude;
        logic                    last_pair;
    } t_out_item;

    // One kept pair as held in the sorted store.
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] val;
        logic [MAG_W-1:0] mag;
    } t_slot;

    // Classified item passed from the front to the back through the queue.
    typedef struct packed {
        t_slot slot;
        logic  is_pair;
        logic  last;
    } t_queue_item;

endpackage

FILE: rtl/tkm_queue.sv
// Small FIFO between the classifying front and the sorting back.
module tkm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tkm_pkg::t_queue_item i_push_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tkm_pkg::t_queue_item o_head
);
    import tkm_pkg::*;

    t_queue_item       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_fill, n_fill;
    logic              do_push, do_pop;

    assign o_full  = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: rtl/tkm_front.sv
// Input side: accept matrix entries, keep upper-triangle pairs, form magnitudes.
module tkm_front #(
    parameter int MAX_GENES = tkm_pkg::MAX_GENES_DEF
) (
    input  logic                 i_in_valid,
    input  tkm_pkg::t_in_item    i_in_item,
    output logic                 o_in_stall,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output tkm_pkg::t_queue_item o_push_item
);
    import tkm_pkg::*;

    logic             in_range;
    logic [VAL_W-1:0] val_u;
    logic [VAL_W-1:0] neg;
    logic [MAG_W-1:0] mag;

    // Indices are 10 bits wide; compare in 11 bits so MAX_GENES = 1024 works.
    assign in_range = ({1'b0, i_in_item.row_index} < (IDX_W+1)'(MAX_GENES))
                   && ({1'b0, i_in_item.col_index} < (IDX_W+1)'(MAX_GENES));

    assign val_u = i_in_item.entry_value;
    assign neg   = ~val_u + 32'd1;

    // Saturate the magnitude of the most negative value.
    always_comb begin
        if (val_u[VAL_W-1]) begin
            mag = neg[VAL_W-1] ? MAG_MAX : neg[MAG_W-1:0];
        end else begin
            mag = val_u[MAG_W-1:0];
        end
    end

    always_comb begin
        o_push_item.slot.row = i_in_item.row_index;
        o_push_item.slot.col = i_in_item.col_index;
        o_push_item.slot.val = val_u;
        o_push_item.slot.mag = mag;
        o_push_item.is_pair  = in_range && (i_in_item.col_index > i_in_item.row_index);
        o_push_item.last     = i_in_item.last_entry;
    end

    assign o_in_stall = i_queue_full;
    // Drop entries that are neither pairs nor end-of-matrix markers.
    assign o_push = i_in_valid && !i_queue_full
                 && (o_push_item.is_pair || o_push_item.last);

endmodule

FILE: rtl/tkm_back.sv
// Sorted insertion store, k computation and result emission.
module tkm_back #(
    parameter int MAX_KEPT = tkm_pkg::MAX_KEPT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tkm_pkg::FRAC_W-1:0]  i_cfg_data,
    input  logic                        i_queue_empty,
    input  tkm_pkg::t_queue_item        i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tkm_pkg::t_out_item          o_out_data
);
    import tkm_pkg::*;

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int PROD_W = FRAC_W + TOTAL_W;
    localparam int KR_W = PROD_W + 1 - FRAC_BITS;

    localparam logic [1:0] ST_INSERT = 2'd0;
    localparam logic [1:0] ST_MUL    = 2'd1;
    localparam logic [1:0] ST_CLAMP  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [FRAC_W-1:0]  r_frac;
    logic [CW-1:0]      r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [CW-1:0]      r_left, n_left;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    t_slot              r_slot [MAX_KEPT];
    t_slot              n_slot [MAX_KEPT];

    logic               ge      [MAX_KEPT];
    logic               prev_ge [MAX_KEPT];
    t_slot              up_slot [MAX_KEPT];
    t_slot              dn_slot [MAX_KEPT];
    logic               out_load;
    logic [PROD_W:0]    rounded;
    logic [KR_W-1:0]    k_val;

    assign o_cfg_ready = 1'b1;
    assign o_pop       = (r_state == ST_INSERT) && !i_queue_empty;
    assign out_load    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Per-slot compare against the incoming magnitude; ties stay ahead.
    always_comb begin
        for (int i = 0; i < MAX_KEPT; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_slot[i].mag >= i_head.slot.mag);
        end
        prev_ge[0] = 1'b1;
        up_slot[0] = r_slot[0];
        for (int i = 1; i < MAX_KEPT; i++) begin
            prev_ge[i] = ge[i-1];
            up_slot[i] = r_slot[i-1];
        end
        for (int i = 0; i < MAX_KEPT - 1; i++) begin
            dn_slot[i] = r_slot[i+1];
        end
        dn_slot[MAX_KEPT-1] = r_slot[MAX_KEPT-1];
    end

    always_comb begin
        rounded = {1'b0, r_prod} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
        k_val   = rounded[PROD_W:FRAC_BITS];
        if (k_val == '0) begin
            k_val = KR_W'(1);
        end
        if (k_val > KR_W'(r_total)) begin
            k_val = KR_W'(r_total);
        end
        if (k_val > KR_W'(r_count)) begin
            k_val = KR_W'(r_count);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_prod      = r_prod;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        for (int i = 0; i < MAX_KEPT; i++) begin
            n_slot[i] = r_slot[i];
        end
        if (out_load) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_INSERT: begin
                if (!i_queue_empty) begin
                    if (i_head.is_pair) begin
                        if (r_total != TOTAL_MAX) begin
                            n_total = r_total + 1'b1;
                        end
                        if (r_count != CW'(MAX_KEPT)) begin
                            n_count = r_count + 1'b1;
                        end
                        for (int i = 0; i < MAX_KEPT; i++) begin
                            if (!ge[i]) begin
                                n_slot[i] = prev_ge[i] ? i_head.slot : up_slot[i];
                            end
                        end
                    end
                    if (i_head.last) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_prod  = PROD_W'(r_frac) * PROD_W'(r_total);
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (r_total == '0) begin
                    n_count = '0;
                    n_state = ST_INSERT;
                end else begin
                    n_left  = k_val[CW-1:0];
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid          = 1'b1;
                    n_out.pair_row       = r_slot[0].row;
                    n_out.pair_col       = r_slot[0].col;
                    n_out.pair_value     = r_slot[0].val;
                    n_out.pair_magnitude = r_slot[0].mag;
                    n_out.last_pair      = (r_left == CW'(1));
                    n_left               = r_left - 1'b1;
                    for (int i = 0; i < MAX_KEPT; i++) begin
                        n_slot[i] = dn_slot[i];
                    end
                    if (r_left == CW'(1)) begin
                        n_count = '0;
                        n_total = '0;
                        n_state = ST_INSERT;
                    end
                end
            end
            default: begin
                n_state = ST_INSERT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INSERT;
            r_frac      <= FRAC_RESET;
            r_count     <= '0;
            r_total     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_frac <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_out  <= n_out;
        for (int i = 0; i < MAX_KEPT; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEPT))
        else $error("kept count beyond store size");

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0) && (r_left <= r_count))
        else $error("emit count out of range");

    a_mul_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_CLAMP))
        else $error("multiply step not followed by clamp");

    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && out_load && (r_left == CW'(1))
        |=> (r_state == ST_INSERT) && (r_count == '0) && (r_total == '0)
            && o_out_valid && o_out_data.last_pair)
        else $error("matrix state not cleared after final pair");

endmodule

FILE: rtl/top_k_magnitude_pair_select.sv
// Top level of the top-k magnitude pair selector.
//
//   channel | direction | handshake              | carries
//   --------+-----------+------------------------+--------------------------------
//   in      | input     | i_in_valid / o_in_stall  | t_in_item, one matrix entry
//   out     | output    | o_out_valid / i_out_stall| t_out_item, one reported pair
//   cfg     | input     | i_cfg_valid / o_cfg_ready| keep_fraction, unsigned Q1.16
//
// Entries are taken one per cycle into a four-deep queue while it is not full;
// in the insert state the back end inserts one queued pair per cycle into a
// MAX_KEPT-slot sorted shift store. After the last entry the back end forms k
// by a multiply, then a round-and-clamp, and then shifts out k pairs at one per
// cycle while the output is not stalled; the front keeps filling the queue meanwhile.
// Reset is synchronous and active low; it empties the queue and the store,
// and keep_fraction returns to 655. No clearing pass is needed after reset.
// An output stall holds the result register and pauses emission; once the
// queue is full the input stalls as well until the back end drains it.
module top_k_magnitude_pair_select #(
    parameter int MAX_GENES = tkm_pkg::MAX_GENES_DEF,
    parameter int MAX_KEPT  = tkm_pkg::MAX_KEPT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tkm_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tkm_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tkm_pkg::FRAC_W-1:0] i_cfg_data
);
    import tkm_pkg::*;

    // Front to queue: classified entries, pairs and end-of-matrix markers only.
    logic        push;
    t_queue_item push_item;
    logic        queue_full;

    // Queue to back: head transaction and pop.
    logic        pop;
    logic        queue_empty;
    t_queue_item head;

    tkm_front #(
        .MAX_GENES (MAX_GENES)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_item  (push_item)
    );

    // Decouple the input stream from the store while results are draining.
    tkm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_empty     (queue_empty),
        .o_head      (head)
    );

    // Hold the sorted store, compute k on the last entry and emit the pairs.
    tkm_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_queue_empty (queue_empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

FILE: dv/tb_top_k_magnitude_pair_select.sv
// Self-checking testbench for the top-k magnitude pair selector.
`timescale 1ns / 100ps

module tb_top_k_magnitude_pair_select;
    import tkm_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 24;    // queue depth + k forming, with margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PAIRS   = 100;
    localparam int MAX_KEPT       = MAX_KEPT_DEF;
    localparam int MAX_GENES      = MAX_GENES_DEF;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [FRAC_W-1:0]   i_cfg_data  = '0;

    // Predictor state: the sorted store of kept pairs and the pair counter.
    t_slot               kept_pairs[$];
    logic [TOTAL_W-1:0]  pair_total    = '0;
    logic [FRAC_W-1:0]   keep_fraction = FRAC_RESET;
    t_out_item           expected_pairs[$];

    int  mismatches    = 0;
    int  entries_sent  = 0;
    int  pairs_seen    = 0;
    int  matrices_sent = 0;
    int  pairs_checked = 0;
    int  cfg_writes    = 0;
    int  stall_left    = 0;
    int  idle_cycles   = 0;
    bit  bursts_on     = 1'b1;

    top_k_magnitude_pair_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Absolute value, saturating the most negative code to the largest magnitude.
    function automatic logic [MAG_W-1:0] abs_sat(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] neg;
        if (!v[VAL_W-1])
            return v[MAG_W-1:0];
        neg = -v;
        if (neg[VAL_W-1])
            return MAG_MAX;
        return neg[MAG_W-1:0];
    endfunction

    function automatic t_in_item pack_entry(input int r, input int c,
                                            input logic [VAL_W-1:0] v, input bit last);
        t_in_item e;
        e.row_index   = r[IDX_W-1:0];
        e.col_index   = c[IDX_W-1:0];
        e.entry_value = v;
        e.last_entry  = last;
        return e;
    endfunction

    // Mix of wide random values, tiny values that tie often, and the extremes.
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return $urandom_range(0, 1) ? 32'($urandom_range(0, 15))
                                                 : -32'($urandom_range(0, 15));
            6: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h8000_0001;
                    3: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom) >>> $urandom_range(8, 24));
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] rand_fraction();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(1000, 65536));
        endcase
    endfunction

    // Take one accepted entry into the predictor; on the last entry queue up the
    // k largest pairs and clear for the next matrix.
    task automatic rank_entry(input t_in_item e);
        t_slot             s;
        int                pos;
        longint unsigned   k;
        t_out_item         o;
        if (e.col_index > e.row_index && int'(e.row_index) < MAX_GENES
                && int'(e.col_index) < MAX_GENES) begin
            pairs_seen++;
            if (pair_total != TOTAL_MAX)
                pair_total++;
            s.row = e.row_index;
            s.col = e.col_index;
            s.val = e.entry_value;
            s.mag = abs_sat(e.entry_value);
            // Stable: a newcomer goes behind every entry of equal magnitude.
            pos = 0;
            while (pos < kept_pairs.size() && kept_pairs[pos].mag >= s.mag)
                pos++;
            if (pos < MAX_KEPT) begin
                kept_pairs.insert(pos, s);
                if (kept_pairs.size() > MAX_KEPT)
                    void'(kept_pairs.pop_back());
            end
        end
        if (!e.last_entry)
            return;
        if (pair_total != 0) begin
            k = (64'(keep_fraction) * 64'(pair_total) + 64'd32768) >> FRAC_BITS;
            if (k < 1)
                k = 1;
            if (k > 64'(pair_total))
                k = 64'(pair_total);
            if (k > 64'(kept_pairs.size()))
                k = 64'(kept_pairs.size());
            for (int i = 0; i < int'(k); i++) begin
                o.pair_row       = kept_pairs[i].row;
                o.pair_col       = kept_pairs[i].col;
                o.pair_value     = kept_pairs[i].val;
                o.pair_magnitude = kept_pairs[i].mag;
                o.last_pair      = (i + 1 == int'(k));
                expected_pairs.insert(expected_pairs.size(), o);
            end
        end
        kept_pairs.delete();
        pair_total = '0;
    endtask

    // Send one entry, with an optional random gap first; valid stays high on return.
    task automatic send_entry(input t_in_item e);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= e;
        do @(posedge i_clk); while (o_in_stall);
        rank_entry(e);
        entries_sent++;
    endtask

    // Drop valid, hold until every expected pair is out, then let the pipe settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keep_fraction(input logic [FRAC_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        keep_fraction = value;
        cfg_writes++;
    endtask

    // Random matrix of n entries; noise_pct percent of them sit on or below the diagonal.
    task automatic send_matrix(input int n_entries, input int noise_pct);
        int r;
        int c;
        for (int i = 0; i < n_entries; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                r = $urandom_range(0, 1023);
                c = $urandom_range(0, r);
            end else begin
                r = $urandom_range(0, 1022);
                c = $urandom_range(r + 1, 1023);
            end
            send_entry(pack_entry(r, c, rand_value(), i == n_entries - 1));
        end
        matrices_sent++;
    endtask

    // Index extremes, value extremes, ties, ignored entries, empty matrices.
    task automatic test_corner_entries();
        // Reset fraction: k rounds to zero and is raised to one.
        send_entry(pack_entry(0, 1023, 32'h7FFF_FFFF, 0));
        send_entry(pack_entry(5, 5, 32'h1234_5678, 0));
        send_entry(pack_entry(1023, 0, 32'h7FFF_FFFF, 0));
        send_entry(pack_entry(0, 1, 32'h8000_0000, 0));
        send_entry(pack_entry(1022, 1023, 32'h0, 0));
        send_entry(pack_entry(3, 2, 32'hFFFF_FFFF, 1));
        matrices_sent++;
        wait_drained();
        write_keep_fraction(17'd65536);
        // Equal magnitudes of both signs must come out in arrival order.
        send_entry(pack_entry(2, 3, 32'd100, 0));
        send_entry(pack_entry(4, 5, -32'd100, 0));
        send_entry(pack_entry(1, 2, -32'd100, 0));
        send_entry(pack_entry(6, 7, 32'd50, 0));
        send_entry(pack_entry(0, 1, 32'h8000_0000, 0));
        send_entry(pack_entry(8, 9, 32'hFFFF_FFFF, 0));
        send_entry(pack_entry(9, 9, 32'd7, 1));
        // Last entry alone on the diagonal: no pairs, no result.
        send_entry(pack_entry(7, 7, 32'hDEAD_BEEF, 1));
        send_entry(pack_entry(0, 1, -32'd5, 1));
        send_entry(pack_entry(1023, 1022, 32'd9, 0));
        send_entry(pack_entry(1023, 1023, 32'd9, 1));
        matrices_sent += 4;
        wait_drained();
    endtask

    // Walk the register through its extremes and a few points between.
    task automatic test_fraction_settings();
        logic [FRAC_W-1:0] settings[6] = '{17'd0, 17'h1FFFF, 17'd65536, 17'd32768,
                                           17'd1, 17'd98304};
        foreach (settings[i]) begin
            write_keep_fraction(settings[i]);
            send_matrix($urandom_range(3, 20), 10);
            wait_drained();
        end
    endtask

    // Overfill the store with small, often equal magnitudes so ties sit at the cut.
    task automatic test_store_overflow();
        write_keep_fraction(17'd65536);
        for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < 100; i++)
                send_entry(pack_entry(i % 1023, 1023, $urandom_range(0, 1) ?
                                      32'($urandom_range(0, 7)) : -32'($urandom_range(0, 7)),
                                      i == 99));
            matrices_sent++;
        end
        wait_drained();
        write_keep_fraction(17'h1FFFF);
        send_matrix(90, 0);
        wait_drained();
    endtask

    // Back-to-back random matrices with occasional drains and register changes;
    // the tail runs with no idling on either side.
    task automatic test_random_matrices();
        int start_pairs;
        int n;
        start_pairs = pairs_seen;
        while (pairs_seen - start_pairs < RANDOM_PAIRS) begin
            if (pairs_seen - start_pairs > RANDOM_PAIRS - 30)
                bursts_on = 1'b0;
            case ($urandom_range(0, 9))
                0: begin
                    wait_drained();
                    write_keep_fraction(rand_fraction());
                end
                1: wait_drained();
                default: ;
            endcase
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(65, 100) : $urandom_range(1, 20);
            send_matrix(n, ($urandom_range(0, 9) == 0) ? 100 : 10);
        end
    endtask

    // Check each accepted pair against the oldest prediction; drive output stall bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pairs.size() == 0) begin
                $error("unexpected pair row %0d col %0d", o_out_data.pair_row,
                       o_out_data.pair_col);
                mismatches++;
            end else begin
                automatic t_out_item want = expected_pairs.pop_front();
                if (o_out_data.pair_row !== want.pair_row) begin
                    $error("pair_row: expected %0d, actual %0d", want.pair_row,
                           o_out_data.pair_row);
                    mismatches++;
                end
                if (o_out_data.pair_col !== want.pair_col) begin
                    $error("pair_col: expected %0d, actual %0d", want.pair_col,
                           o_out_data.pair_col);
                    mismatches++;
                end
                if (o_out_data.pair_value !== want.pair_value) begin
                    $error("pair_value: expected %h, actual %h", want.pair_value,
                           o_out_data.pair_value);
                    mismatches++;
                end
                if (o_out_data.pair_magnitude !== want.pair_magnitude) begin
                    $error("pair_magnitude: expected %h, actual %h", want.pair_magnitude,
                           o_out_data.pair_magnitude);
                    mismatches++;
                end
                if (o_out_data.last_pair !== want.last_pair) begin
                    $error("last_pair: expected %0b, actual %0b", want.last_pair,
                           o_out_data.last_pair);
                    mismatches++;
                end
                pairs_checked++;
            end
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Count cycles with no transaction on any channel; give up past the limit.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_entries();
        test_fraction_settings();
        test_store_overflow();
        test_random_matrices();
        wait_drained();
        $display("Sent %0d entries (%0d upper-triangle pairs) in %0d matrices,",
                 entries_sent, pairs_seen, matrices_sent);
        $display("checked %0d reported pairs across %0d fraction writes.",
                 pairs_checked, cfg_writes);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: top_k_magnitude_pair_select.f
rtl/tkm_pkg.sv
rtl/tkm_queue.sv
rtl/tkm_front.sv
rtl/tkm_back.sv
rtl/top_k_magnitude_pair_select.sv
dv/tb_top_k_magnitude_pair_select.sv
